/* sv/csimu_pkg.sv */
package csimu_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int MAX_ANTENNAS = 4;
    localparam int MAX_TONES    = 128;

    localparam int BYTE_W      = 8;
    localparam int PAIR_BITS   = 2 * SAMPLE_BITS;
    localparam int BUF_W       = PAIR_BITS + BYTE_W - 1;
    localparam int HELD_W      = $clog2(BUF_W + 1);
    localparam int ANT_W       = $clog2(MAX_ANTENNAS);
    localparam int TONE_W      = $clog2(MAX_TONES);
    localparam int ANT_CFG_W   = 3;
    localparam int TONE_CFG_W  = 8;
    localparam int ANT_CNT_W   = ANT_W + 1;
    localparam int TONE_CNT_W  = TONE_W + 1;
    localparam int PROD_W      = ANT_CNT_W + TONE_CNT_W;
    localparam int POS_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RX_ANTENNAS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_ANTENNAS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_COUNT  = 2'd2;

    localparam logic [ANT_CFG_W-1:0]  RX_ANTENNAS_RST = 3'd1;
    localparam logic [ANT_CFG_W-1:0]  TX_ANTENNAS_RST = 3'd1;
    localparam logic [TONE_CFG_W-1:0] TONE_COUNT_RST  = 8'd56;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [ANT_W-1:0]  rx;
        logic [ANT_W-1:0]  tx;
        logic [TONE_W-1:0] tone;
        logic [POS_W-1:0]  pos;
        logic              last;
    } entry_idx_t;

endpackage

/* sv/csimu_byte_if.sv */
interface csimu_byte_if;
    logic                          valid;
    logic                          ready;
    logic [csimu_pkg::BYTE_W-1:0]  raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink (input valid, input raw_byte, output ready);
endinterface

/* sv/csimu_entry_if.sv */
interface csimu_entry_if;
    logic                          valid;
    logic                          ready;
    csimu_pkg::sample_t            real_part;
    csimu_pkg::sample_t            imag_part;
    logic [csimu_pkg::ANT_W-1:0]   rx_index;
    logic [csimu_pkg::ANT_W-1:0]   tx_index;
    logic [csimu_pkg::TONE_W-1:0]  tone_index;
    logic [csimu_pkg::POS_W-1:0]   entry_position;
    logic                          last_entry;

    modport source (
        output valid, output real_part, output imag_part, output rx_index,
        output tx_index, output tone_index, output entry_position,
        output last_entry, input ready
    );
    modport sink (
        input valid, input real_part, input imag_part, input rx_index,
        input tx_index, input tone_index, input entry_position,
        input last_entry, output ready
    );
endinterface

/* sv/csimu_counter.sv */
module csimu_counter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [csimu_pkg::ANT_CFG_W-1:0]     rx_antennas,
    input  logic [csimu_pkg::ANT_CFG_W-1:0]     tx_antennas,
    input  logic [csimu_pkg::TONE_CFG_W-1:0]    tone_count,
    input  logic                                advance,
    output csimu_pkg::entry_idx_t               idx
);
    import csimu_pkg::*;

    logic [ANT_W-1:0]      rx_cnt_reg, rx_cnt_next;
    logic [ANT_W-1:0]      tx_cnt_reg, tx_cnt_next;
    logic [TONE_W-1:0]     tone_cnt_reg, tone_cnt_next;
    logic [PROD_W-1:0]     plane;
    logic [ANT_CNT_W-1:0]  nrx, ntx;
    logic [TONE_CNT_W-1:0] ntone;
    logic                  rx_end, tx_end, tone_end;
    logic [PROD_W+ANT_W:0] pos_sum;

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (rx_antennas == '0)
            nrx = ANT_CNT_W'(1);
        else if (ANT_CNT_W'(rx_antennas) > ANT_CNT_W'(MAX_ANTENNAS))
            nrx = ANT_CNT_W'(MAX_ANTENNAS);
        else
            nrx = ANT_CNT_W'(rx_antennas);

        if (tx_antennas == '0)
            ntx = ANT_CNT_W'(1);
        else if (ANT_CNT_W'(tx_antennas) > ANT_CNT_W'(MAX_ANTENNAS))
            ntx = ANT_CNT_W'(MAX_ANTENNAS);
        else
            ntx = ANT_CNT_W'(tx_antennas);

        if (tone_count == '0)
            ntone = TONE_CNT_W'(1);
        else if (TONE_CNT_W'(tone_count) > TONE_CNT_W'(MAX_TONES))
            ntone = TONE_CNT_W'(MAX_TONES);
        else
            ntone = TONE_CNT_W'(tone_count);
    end

    // rx-by-tone plane size
    assign plane = PROD_W'(nrx) * PROD_W'(ntone);

    assign rx_end   = (ANT_CNT_W'(rx_cnt_reg) + ANT_CNT_W'(1)) >= nrx;
    assign tx_end   = (ANT_CNT_W'(tx_cnt_reg) + ANT_CNT_W'(1)) >= ntx;
    assign tone_end = (TONE_CNT_W'(tone_cnt_reg) + TONE_CNT_W'(1)) >= ntone;

    assign pos_sum = (PROD_W+ANT_W+1)'(tx_cnt_reg) * (PROD_W+ANT_W+1)'(plane)
                   + (PROD_W+ANT_W+1)'(rx_cnt_reg) * (PROD_W+ANT_W+1)'(ntone)
                   + (PROD_W+ANT_W+1)'(tone_cnt_reg);

    assign idx.rx   = rx_cnt_reg;
    assign idx.tx   = tx_cnt_reg;
    assign idx.tone = tone_cnt_reg;
    assign idx.pos  = pos_sum[POS_W-1:0];
    assign idx.last = rx_end && tx_end && tone_end;

    always_comb
    begin
        rx_cnt_next   = rx_cnt_reg;
        tx_cnt_next   = tx_cnt_reg;
        tone_cnt_next = tone_cnt_reg;
        if (advance)
        begin
            if (idx.last)
            begin
                rx_cnt_next   = '0;
                tx_cnt_next   = '0;
                tone_cnt_next = '0;
            end
            else if (!rx_end)
                rx_cnt_next = rx_cnt_reg + ANT_W'(1);
            else
            begin
                rx_cnt_next = '0;
                if (!tx_end)
                    tx_cnt_next = tx_cnt_reg + ANT_W'(1);
                else
                begin
                    tx_cnt_next   = '0;
                    tone_cnt_next = tone_end ? '0 : tone_cnt_reg + TONE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_cnt_reg   <= '0;
            tx_cnt_reg   <= '0;
            tone_cnt_reg <= '0;
        end
        else
        begin
            rx_cnt_reg   <= rx_cnt_next;
            tx_cnt_reg   <= tx_cnt_next;
            tone_cnt_reg <= tone_cnt_next;
        end
    end

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && idx.last |=> rx_cnt_reg == '0 && tx_cnt_reg == '0 && tone_cnt_reg == '0)
        else $error("counters did not restart after final entry");

    a_rx_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !idx.last && rx_end |=> rx_cnt_reg == '0)
        else $error("rx counter did not wrap");

    a_tone_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !rx_end |=> $stable(tone_cnt_reg) && $stable(tx_cnt_reg))
        else $error("outer counters moved while rx counter advanced");

endmodule

/* sv/csi_matrix_unpacker_top.sv */
// packed CSI report unpacker
//
// byte_in carries the report one byte per transfer; bits are taken lsb first
// and each pair of 10-bit two's-complement values (imaginary, then real) forms
// one complex entry. entry_out carries each entry with its rx, tx and tone
// indices, its linear matrix position and a flag on the final entry of the
// matrix. After that entry the leftover bits are dropped and a new matrix
// starts with the next byte.
// One byte is taken every cycle unless entry_out stalls. An entry appears on
// entry_out in the cycle after the byte that completes it; bytes that complete
// no entry give no transfer. The result register decouples the two sides:
// byte_in stays ready while the held entry is taken in the same cycle, and
// when entry_out stalls byte_in drops ready until the entry is taken.
// cfg_write with cfg_index/cfg_data sets rx_antennas, tx_antennas and
// tone_count; write only while no entry is pending. The new values apply from
// the next byte on. Reset clears the bit buffer and counters and restores
// 1 rx, 1 tx and 56 tones.
module csi_matrix_unpacker_top (
    input  logic                               clk,
    input  logic                               rst_n,
    csimu_byte_if.sink                         byte_in,
    csimu_entry_if.source                      entry_out,
    input  logic                               cfg_write,
    input  logic [csimu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csimu_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import csimu_pkg::*;

    logic [ANT_CFG_W-1:0]  rx_antennas_reg;
    logic [ANT_CFG_W-1:0]  tx_antennas_reg;
    logic [TONE_CFG_W-1:0] tone_count_reg;

    logic [BUF_W-1:0]      buf_reg, buf_next;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [BUF_W-1:0]      merged;
    logic [HELD_W-1:0]     held_sum;
    logic                  accept, emit, advance;
    entry_idx_t            idx;

    logic                  out_valid_reg;
    sample_t               real_reg, imag_reg;
    entry_idx_t            idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_antennas_reg <= RX_ANTENNAS_RST;
            tx_antennas_reg <= TX_ANTENNAS_RST;
            tone_count_reg  <= TONE_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RX_ANTENNAS: rx_antennas_reg <= cfg_data[ANT_CFG_W-1:0];
                CFG_TX_ANTENNAS: tx_antennas_reg <= cfg_data[ANT_CFG_W-1:0];
                CFG_TONE_COUNT:  tone_count_reg  <= cfg_data[TONE_CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    csimu_counter u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_antennas (rx_antennas_reg),
        .tx_antennas (tx_antennas_reg),
        .tone_count  (tone_count_reg),
        .advance     (advance),
        .idx         (idx)
    );

    assign byte_in.ready = !out_valid_reg || entry_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    // new byte lands above the bits already held
    assign merged   = buf_reg | (BUF_W'(byte_in.raw_byte) << held_reg);
    assign held_sum = held_reg + HELD_W'(BYTE_W);
    assign emit     = held_sum >= HELD_W'(PAIR_BITS);
    assign advance  = accept && emit;

    always_comb
    begin
        buf_next  = buf_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (!emit)
            begin
                buf_next  = merged;
                held_next = held_sum;
            end
            else if (idx.last)
            begin
                buf_next  = '0;
                held_next = '0;
            end
            else
            begin
                buf_next  = merged >> PAIR_BITS;
                held_next = held_sum - HELD_W'(PAIR_BITS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (entry_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            imag_reg <= sample_t'(merged[SAMPLE_BITS-1:0]);
            real_reg <= sample_t'(merged[PAIR_BITS-1:SAMPLE_BITS]);
            idx_reg  <= idx;
        end
    end

    assign entry_out.valid          = out_valid_reg;
    assign entry_out.real_part      = real_reg;
    assign entry_out.imag_part      = imag_reg;
    assign entry_out.rx_index       = idx_reg.rx;
    assign entry_out.tx_index       = idx_reg.tx;
    assign entry_out.tone_index     = idx_reg.tone;
    assign entry_out.entry_position = idx_reg.pos;
    assign entry_out.last_entry     = idx_reg.last;

    a_held_below_pair: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg < HELD_W'(PAIR_BITS))
        else $error("bit buffer holds a whole entry");

    a_buf_clean_above: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_reg >> held_reg) == '0)
        else $error("stale bits above the held count");

    a_entry_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !$past(out_valid_reg) |-> $past(byte_in.valid && byte_in.ready))
        else $error("entry raised without a byte transfer");

endmodule

/* tb/tb.sv */
module tb;
    import csimu_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    csimu_byte_if  byte_ch ();
    csimu_entry_if entry_ch ();

    csi_matrix_unpacker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .entry_out (entry_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        sample_t           real_part;
        sample_t           imag_part;
        logic [ANT_W-1:0]  rx_index;
        logic [ANT_W-1:0]  tx_index;
        logic [TONE_W-1:0] tone_index;
        logic [POS_W-1:0]  entry_position;
        logic              last_entry;
    } csi_entry_t;

    class csi_unpack_check;
        logic [ANT_CFG_W-1:0]  rx_antennas;
        logic [ANT_CFG_W-1:0]  tx_antennas;
        logic [TONE_CFG_W-1:0] tone_count;
        logic [BUF_W-1:0]      bit_buf;
        int                    bits_held;
        int                    rx_at;
        int                    tx_at;
        int                    tone_at;
        csi_entry_t            expected_entries[$];
        int                    mismatches;
        int                    bytes_taken;
        int                    entries_checked;
        int                    matrices_done;

        function new();
            rx_antennas     = RX_ANTENNAS_RST;
            tx_antennas     = TX_ANTENNAS_RST;
            tone_count      = TONE_COUNT_RST;
            bit_buf         = '0;
            bits_held       = 0;
            rx_at           = 0;
            tx_at           = 0;
            tone_at         = 0;
            mismatches      = 0;
            bytes_taken     = 0;
            entries_checked = 0;
            matrices_done   = 0;
        endfunction

        // zero acts as one, oversize counts saturate
        static function int effective(int v, int hi);
            if (v == 0)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_RX_ANTENNAS: rx_antennas = val[ANT_CFG_W-1:0];
                CFG_TX_ANTENNAS: tx_antennas = val[ANT_CFG_W-1:0];
                CFG_TONE_COUNT:  tone_count  = val[TONE_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            int         nrx;
            int         ntx;
            int         ntone;
            int         pos;
            bit         rx_end;
            bit         tx_end;
            bit         tone_end;
            csi_entry_t e;
            bytes_taken++;
            bit_buf   = bit_buf | (BUF_W'(b) << bits_held);
            bits_held = bits_held + BYTE_W;
            if (bits_held < PAIR_BITS)
                return;
            nrx   = effective(rx_antennas, MAX_ANTENNAS);
            ntx   = effective(tx_antennas, MAX_ANTENNAS);
            ntone = effective(tone_count, MAX_TONES);
            e.imag_part = bit_buf[SAMPLE_BITS-1:0];
            e.real_part = bit_buf[PAIR_BITS-1:SAMPLE_BITS];
            bit_buf   = bit_buf >> PAIR_BITS;
            bits_held = bits_held - PAIR_BITS;
            pos      = tx_at * (nrx * ntone) + rx_at * ntone + tone_at;
            rx_end   = rx_at + 1 >= nrx;
            tx_end   = tx_at + 1 >= ntx;
            tone_end = tone_at + 1 >= ntone;
            e.rx_index       = ANT_W'(rx_at);
            e.tx_index       = ANT_W'(tx_at);
            e.tone_index     = TONE_W'(tone_at);
            e.entry_position = POS_W'(pos);
            e.last_entry     = rx_end && tx_end && tone_end;
            expected_entries.push_back(e);
            // a counter past a reduced limit counts as its last value
            if (e.last_entry)
            begin
                bit_buf   = '0;
                bits_held = 0;
                rx_at     = 0;
                tx_at     = 0;
                tone_at   = 0;
            end
            else if (!rx_end)
                rx_at++;
            else
            begin
                rx_at = 0;
                if (!tx_end)
                    tx_at++;
                else
                begin
                    tx_at   = 0;
                    tone_at = tone_end ? 0 : tone_at + 1;
                end
            end
        endfunction

        function void compare_field(string name, integer want, integer got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_entry(csi_entry_t got);
            csi_entry_t want;
            if (expected_entries.size() == 0)
            begin
                $error("entry transfer with no entry expected");
                mismatches++;
                return;
            end
            want = expected_entries.pop_front();
            compare_field("real_part", want.real_part, got.real_part);
            compare_field("imag_part", want.imag_part, got.imag_part);
            compare_field("rx_index", want.rx_index, got.rx_index);
            compare_field("tx_index", want.tx_index, got.tx_index);
            compare_field("tone_index", want.tone_index, got.tone_index);
            compare_field("entry_position", want.entry_position, got.entry_position);
            compare_field("last_entry", want.last_entry, got.last_entry);
            entries_checked++;
            if (want.last_entry)
                matrices_done++;
        endfunction
    endclass

    csi_unpack_check unpack = new();

    bit sender_gaps;
    bit receiver_gaps;
    bit long_hold;
    int long_holds;
    int settings_used;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // both transfers are sampled on the rising edge, before the block updates
    always @(posedge clk)
    begin
        csi_entry_t seen;
        if (rst_n)
        begin
            if (entry_ch.valid && entry_ch.ready)
            begin
                seen.real_part      = entry_ch.real_part;
                seen.imag_part      = entry_ch.imag_part;
                seen.rx_index       = entry_ch.rx_index;
                seen.tx_index       = entry_ch.tx_index;
                seen.tone_index     = entry_ch.tone_index;
                seen.entry_position = entry_ch.entry_position;
                seen.last_entry     = entry_ch.last_entry;
                unpack.compare_entry(seen);
            end
            if (byte_ch.valid && byte_ch.ready)
                unpack.take_byte(byte_ch.raw_byte);
        end
    end

    // receiver side
    initial
    begin
        int hold;
        entry_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                hold      = 100;
                long_hold = 1'b0;
                long_holds++;
            end
            else
                hold = receiver_gaps ? $urandom_range(0, 12) : 0;
            if (hold > 0)
            begin
                entry_ch.ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            entry_ch.ready = 1'b1;
            @(posedge clk);
            while (!entry_ch.valid)
                @(posedge clk);
        end
    end

    task automatic send_byte(logic [BYTE_W-1:0] b);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            byte_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid    = 1'b1;
        byte_ch.raw_byte = b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int n);
        repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // let the last entry drain and any partial byte settle before a register write
    task automatic wait_drained();
        byte_ch.valid = 1'b0;
        while (unpack.expected_entries.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        unpack.set_register(idx, val);
        @(negedge clk);
    endtask

    task automatic set_matrix(logic [CFG_DATA_W-1:0] rx, logic [CFG_DATA_W-1:0] tx,
                              logic [CFG_DATA_W-1:0] tones);
        write_reg(CFG_RX_ANTENNAS, rx);
        write_reg(CFG_TX_ANTENNAS, tx);
        write_reg(CFG_TONE_COUNT, tones);
        settings_used++;
    endtask

    initial
    begin
        #5_000_000;
        $display("csi_matrix_unpacker_top verification failed");
        $finish;
    end

    initial
    begin
        int                    random_bytes;
        int                    nbytes;
        int                    entries;
        int                    matrix_bytes;
        int                    phase;
        int                    settle;
        logic [CFG_DATA_W-1:0] rx_data;
        logic [CFG_DATA_W-1:0] tx_data;
        logic [CFG_DATA_W-1:0] tone_data;

        byte_ch.valid    = 1'b0;
        byte_ch.raw_byte = '0;
        cfg_write        = 1'b0;
        cfg_index        = CFG_RX_ANTENNAS;
        cfg_data         = '0;
        sender_gaps      = 1'b1;
        receiver_gaps    = 1'b1;
        long_hold        = 1'b0;
        long_holds       = 0;
        settings_used    = 1;
        random_bytes     = 0;
        phase            = 0;
        rst_n            = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset setting: 1 x 1 x 56, mask patterns across byte boundaries
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h0F);
        send_byte(8'hF0);
        send_byte(8'h3F);
        send_byte(8'hC0);
        // tone counter now beyond the shrunk tone count, so the next entry closes the matrix
        write_reg(CFG_TONE_COUNT, 8'd2);
        send_byte(8'h12);
        send_byte(8'h34);
        // all counts zero behave as one: every entry is last; sample extremes
        set_matrix(8'd0, 8'd0, 8'd0);
        send_byte(8'h00);
        send_byte(8'hFE);
        send_byte(8'h07);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h08);
        // oversize counts saturate, upper data bits of the antenna registers ignored
        set_matrix(8'hFF, 8'd7, 8'd255);
        send_random(5);
        // rx counter left above the new limit
        set_matrix(8'd1, 8'd1, 8'd1);
        send_random(3);

        while (random_bytes < 100)
        begin
            phase++;
            sender_gaps   = $urandom_range(0, 3) != 0;
            receiver_gaps = $urandom_range(0, 3) != 0;
            rx_data   = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                    : CFG_DATA_W'($urandom_range(0, 7));
            tx_data   = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                    : CFG_DATA_W'($urandom_range(0, 7));
            tone_data = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                    : CFG_DATA_W'($urandom_range(0, 6));
            set_matrix(rx_data, tx_data, tone_data);
            entries = csi_unpack_check::effective(rx_data[ANT_CFG_W-1:0], MAX_ANTENNAS)
                    * csi_unpack_check::effective(tx_data[ANT_CFG_W-1:0], MAX_ANTENNAS)
                    * csi_unpack_check::effective(tone_data, MAX_TONES);
            matrix_bytes = (entries * PAIR_BITS + BYTE_W - 1) / BYTE_W;
            if (matrix_bytes <= 40)
                nbytes = matrix_bytes * $urandom_range(1, 3) + $urandom_range(0, 4);
            else
                nbytes = $urandom_range(10, 60);
            // fill the block while the receiver stalls for a long stretch
            if (phase == 1)
            begin
                long_hold   = 1'b1;
                sender_gaps = 1'b0;
                nbytes      = 80;
            end
            send_random(nbytes);
            random_bytes += nbytes;
        end

        // largest antenna grid, then the largest tone count, without idling
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        set_matrix(8'd4, 8'd4, 8'd2);
        send_random(80);
        set_matrix(8'd1, 8'd1, 8'd128);
        send_random(320);

        byte_ch.valid = 1'b0;
        settle = 0;
        while (unpack.expected_entries.size() != 0 && settle < 2000)
        begin
            @(negedge clk);
            settle++;
        end
        repeat (10) @(negedge clk);
        if (unpack.expected_entries.size() != 0)
        begin
            $error("%0d entries never arrived", unpack.expected_entries.size());
            unpack.mismatches++;
        end

        $display("covered %0d bytes over %0d register settings: %0d entries, %0d matrices closed",
                 unpack.bytes_taken, settings_used, unpack.entries_checked,
                 unpack.matrices_done);
        $display("receiver held off for a long stretch %0d time(s); %0d mismatches",
                 long_holds, unpack.mismatches);
        if (unpack.mismatches == 0)
            $display("csi_matrix_unpacker_top verification clean");
        else
            $display("csi_matrix_unpacker_top verification failed");
        $finish;
    end
endmodule

/* files.f */
sv/csimu_pkg.sv
sv/csimu_byte_if.sv
sv/csimu_entry_if.sv
sv/csimu_counter.sv
sv/csi_matrix_unpacker_top.sv
tb/tb.sv
